@@ rtl/bopomofo_syllable_boundary_marker_top_assert.svh @@
// Assertion macros used by the syllable boundary marker core.
`ifndef BOPOMOFO_SYLLABLE_BOUNDARY_MARKER_TOP_ASSERT_SVH
`define BOPOMOFO_SYLLABLE_BOUNDARY_MARKER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BSBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BSBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bsbm_pkg.sv @@
// Package with types, constants and the classifier for the syllable boundary marker.
`timescale 1ns / 1ps

package bsbm_pkg;

    // Field widths of the stream words.
    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int CLASS_W     = 3;
    localparam int INDEX_W     = 6;
    localparam int ERR_W       = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CP_W - CLASS_W - 1 - INDEX_W - ERR_W;

    // Default limit on code points per query.
    localparam int MAX_CODEPOINTS_DEF = 64;

    // Bopomofo ranges and tone marks.
    localparam logic [CP_W-1:0] INITIAL_LO = 21'h003105;
    localparam logic [CP_W-1:0] INITIAL_HI = 21'h003119;
    localparam logic [CP_W-1:0] MEDIAL_LO  = 21'h003127;
    localparam logic [CP_W-1:0] MEDIAL_HI  = 21'h003129;
    localparam logic [CP_W-1:0] FINAL_LO   = 21'h00311A;
    localparam logic [CP_W-1:0] FINAL_HI   = 21'h003126;
    localparam logic [CP_W-1:0] TONE_1     = 21'h0002C9;
    localparam logic [CP_W-1:0] TONE_2     = 21'h0002CA;
    localparam logic [CP_W-1:0] TONE_3     = 21'h0002C7;
    localparam logic [CP_W-1:0] TONE_4     = 21'h0002CB;
    localparam logic [CP_W-1:0] TONE_5     = 21'h0002D9;

    typedef enum logic [CLASS_W-1:0] {
        CLS_INITIAL = 3'd0,
        CLS_MEDIAL  = 3'd1,
        CLS_FINAL   = 3'd2,
        CLS_TONE    = 3'd3,
        CLS_OTHER   = 3'd4
    } char_class_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_TRUNC    = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_t;

    // One input byte as held in the input register.
    typedef struct packed {
        logic [BYTE_W-1:0] query_byte;
        logic              last_byte;
    } in_word_t;

    // Handshake between the input register and the core.
    typedef struct packed {
        logic valid;
        logic take;
    } in_ctrl_t;

    // Class of a completed code point.
    function automatic char_class_t classify(input logic [CP_W-1:0] cp);
        char_class_t cls;
        if (cp inside {[INITIAL_LO:INITIAL_HI]}) begin
            cls = CLS_INITIAL;
        end
        else if (cp inside {[MEDIAL_LO:MEDIAL_HI]}) begin
            cls = CLS_MEDIAL;
        end
        else if (cp inside {[FINAL_LO:FINAL_HI]}) begin
            cls = CLS_FINAL;
        end
        else if (cp inside {TONE_1, TONE_2, TONE_3, TONE_4, TONE_5}) begin
            cls = CLS_TONE;
        end
        else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

endpackage

@@ rtl/bsbm_in_reg.sv @@
// Input register that holds one query byte until the core takes it.
`timescale 1ns / 1ps

module bsbm_in_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [bsbm_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] query_byte
    input  logic                        s_axis_tlast,
    input  logic                        take,
    output logic                        valid,
    output bsbm_pkg::in_word_t          word
);

    logic               valid_reg;
    logic               valid_next;
    bsbm_pkg::in_word_t word_reg;

    // A new word enters when the register is empty or drains this cycle.
    assign s_axis_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = (valid_reg && !take) || (s_axis_tvalid && s_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload is loaded on accept and needs no reset.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            word_reg.query_byte <= s_axis_tdata;
            word_reg.last_byte  <= s_axis_tlast;
        end
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

@@ rtl/bsbm_core.sv @@
// Decode state, syllable flags and result register of the boundary marker.
`timescale 1ns / 1ps

`include "bopomofo_syllable_boundary_marker_top_assert.svh"

module bsbm_core #(
    parameter int MAX_CODEPOINTS = bsbm_pkg::MAX_CODEPOINTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bsbm_pkg::in_word_t               in_word,
    input  logic                             in_valid,
    output bsbm_pkg::in_ctrl_t               in_ctrl,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bsbm_pkg::CP_W-1:0]        out_code_point,
    output bsbm_pkg::char_class_t            out_char_class,
    output logic                             out_boundary_before,
    output logic [bsbm_pkg::INDEX_W-1:0]     out_cp_index,
    output logic                             out_end_of_query,
    output bsbm_pkg::err_t                   out_error
);

    localparam int CNT_W = $clog2(MAX_CODEPOINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CODEPOINTS);

    // Decode and syllable state.
    logic [1:0]                  bytes_left_reg, bytes_left_next;
    logic [bsbm_pkg::CP_W-1:0]   accum_reg, accum_next;
    logic                        init_flag_reg, init_flag_next;
    logic                        med_flag_reg, med_flag_next;
    logic                        fin_flag_reg, fin_flag_next;
    logic                        pending_reg, pending_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        ovf_reg, ovf_next;

    // Result register.
    logic                        out_valid_reg, out_valid_next;
    logic [bsbm_pkg::CP_W-1:0]   cp_reg, cp_next;
    bsbm_pkg::char_class_t       cls_reg, cls_next;
    logic                        bnd_reg, bnd_next;
    logic [bsbm_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic                        eoq_reg, eoq_next;
    bsbm_pkg::err_t              err_reg, err_next;

    // Working signals for the byte in the input register.
    logic                        take;
    logic [bsbm_pkg::BYTE_W-1:0] b;
    logic                        last;
    logic                        done;
    logic                        err_case;
    logic                        any_flag;
    logic                        starts;
    bsbm_pkg::char_class_t       cls;

    // The byte moves on whenever the result register is free or drains.
    assign take         = in_valid && (!out_valid_reg || out_ready);
    assign in_ctrl.valid = in_valid;
    assign in_ctrl.take  = take;
    assign b    = in_word.query_byte;
    assign last = in_word.last_byte;

    // UTF-8 assembly: lead byte sets the length, continuations add six bits.
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        accum_next      = accum_reg;
        ovf_next        = ovf_reg;
        done            = 1'b0;
        if (!ovf_reg)
        begin
            if (bytes_left_reg == 2'd0)
            begin
                if (cnt_reg >= CNT_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else if (!b[7])
                begin
                    accum_next = {13'd0, b};
                    done       = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    accum_next      = {16'd0, b[4:0]};
                    bytes_left_next = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    accum_next      = {17'd0, b[3:0]};
                    bytes_left_next = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    accum_next      = {18'd0, b[2:0]};
                    bytes_left_next = 2'd3;
                end
                else
                begin
                    accum_next = '0;
                    done       = 1'b1;
                end
            end
            else
            begin
                accum_next      = {accum_reg[14:0], b[5:0]};
                bytes_left_next = bytes_left_reg - 2'd1;
                done            = (bytes_left_reg == 2'd1);
            end
        end
    end

    // Class and syllable start of the completed code point.
    always_comb
    begin
        err_case = last && (ovf_next || (bytes_left_next != 2'd0));
        cls      = bsbm_pkg::classify(accum_next);
        any_flag = init_flag_reg || med_flag_reg || fin_flag_reg;
        case (cls)
            bsbm_pkg::CLS_INITIAL: starts = any_flag;
            bsbm_pkg::CLS_OTHER:   starts = any_flag;
            bsbm_pkg::CLS_MEDIAL:  starts = med_flag_reg || fin_flag_reg;
            bsbm_pkg::CLS_FINAL:   starts = fin_flag_reg;
            default:               starts = 1'b0;
        endcase
    end

    // Flag, count and pending updates; the last byte returns all to reset.
    always_comb
    begin
        init_flag_next = init_flag_reg;
        med_flag_next  = med_flag_reg;
        fin_flag_next  = fin_flag_reg;
        pending_next   = pending_reg;
        cnt_next       = cnt_reg;
        if (done && !err_case)
        begin
            init_flag_next = !starts && init_flag_reg;
            med_flag_next  = !starts && med_flag_reg;
            fin_flag_next  = !starts && fin_flag_reg;
            pending_next   = 1'b0;
            case (cls)
                bsbm_pkg::CLS_INITIAL: init_flag_next = 1'b1;
                bsbm_pkg::CLS_MEDIAL:  med_flag_next  = 1'b1;
                bsbm_pkg::CLS_FINAL:   fin_flag_next  = 1'b1;
                bsbm_pkg::CLS_TONE:
                begin
                    init_flag_next = 1'b0;
                    med_flag_next  = 1'b0;
                    fin_flag_next  = 1'b0;
                    pending_next   = 1'b1;
                end
                default: ;
            endcase
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // Result word and its valid bit.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        cp_next        = cp_reg;
        cls_next       = cls_reg;
        bnd_next       = bnd_reg;
        idx_next       = idx_reg;
        eoq_next       = eoq_reg;
        err_next       = err_reg;
        if (take && (err_case || done))
        begin
            out_valid_next = 1'b1;
            idx_next       = bsbm_pkg::INDEX_W'(cnt_reg);
            eoq_next       = last;
            if (err_case)
            begin
                cp_next  = '0;
                cls_next = bsbm_pkg::CLS_OTHER;
                bnd_next = 1'b0;
                err_next = ovf_next ? bsbm_pkg::ERR_OVERFLOW : bsbm_pkg::ERR_TRUNC;
            end
            else
            begin
                cp_next  = accum_next;
                cls_next = cls;
                bnd_next = starts || pending_reg;
                err_next = bsbm_pkg::ERR_NONE;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 2'd0;
            accum_reg      <= '0;
            init_flag_reg  <= 1'b0;
            med_flag_reg   <= 1'b0;
            fin_flag_reg   <= 1'b0;
            pending_reg    <= 1'b1;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                if (last)
                begin
                    bytes_left_reg <= 2'd0;
                    accum_reg      <= '0;
                    init_flag_reg  <= 1'b0;
                    med_flag_reg   <= 1'b0;
                    fin_flag_reg   <= 1'b0;
                    pending_reg    <= 1'b1;
                    cnt_reg        <= '0;
                    ovf_reg        <= 1'b0;
                end
                else
                begin
                    bytes_left_reg <= bytes_left_next;
                    accum_reg      <= accum_next;
                    init_flag_reg  <= init_flag_next;
                    med_flag_reg   <= med_flag_next;
                    fin_flag_reg   <= fin_flag_next;
                    pending_reg    <= pending_next;
                    cnt_reg        <= cnt_next;
                    ovf_reg        <= ovf_next;
                end
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        cp_reg  <= cp_next;
        cls_reg <= cls_next;
        bnd_reg <= bnd_next;
        idx_reg <= idx_next;
        eoq_reg <= eoq_next;
        err_reg <= err_next;
    end

    assign out_valid           = out_valid_reg;
    assign out_code_point      = cp_reg;
    assign out_char_class      = cls_reg;
    assign out_boundary_before = bnd_reg;
    assign out_cp_index        = idx_reg;
    assign out_end_of_query    = eoq_reg;
    assign out_error           = err_reg;

    // Checks on the decode state and the result word.
    `BSBM_ASSERT_NOW(a_cnt_limit, 1'b1, cnt_reg <= CNT_MAX, "code point count above limit")
    `BSBM_ASSERT_NOW(a_ovf_no_partial, bytes_left_reg != 2'd0, !ovf_reg, "overflow inside a character")
    `BSBM_ASSERT_NOW(a_err_at_end, out_valid_reg && (err_reg != bsbm_pkg::ERR_NONE), eoq_reg && !bnd_reg, "error word not at end of query")
    `BSBM_ASSERT_NEXT(a_end_resets, take && last, (cnt_reg == '0) && pending_reg && !ovf_reg && (bytes_left_reg == 2'd0), "state not cleared after last byte")

endmodule

@@ rtl/bopomofo_syllable_boundary_marker_top.sv @@
// Top level of the Bopomofo syllable boundary marker.
//
//  channel   side    contents
//  s_axis    in      tdata[7:0] query_byte, tlast last_byte
//  m_axis    out     tdata code point word, tlast end_of_query
//
// One byte is taken per cycle while m_axis is not stalled; a result passes
// through the input register, then the result register.
// The state update in the core (UTF-8 assembly and syllable flags), done
// for each byte as it is taken, sets this rate.
// Reset is asynchronous, active low, and leaves both registers empty.
// A stall on m_axis holds the result and, through the input register,
// backs up s_axis after one more byte.
`timescale 1ns / 1ps

module bopomofo_syllable_boundary_marker_top #(
    parameter int MAX_CODEPOINTS = bsbm_pkg::MAX_CODEPOINTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bsbm_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] query_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [20:0] code_point, [23:21] char_class, [24] boundary_before,
    // [30:25] cp_index, [32:31] error, [39:33] zero
    output logic [bsbm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast
);

    bsbm_pkg::in_word_t               in_word;
    bsbm_pkg::in_ctrl_t               in_ctrl;
    logic                             in_valid;
    logic [bsbm_pkg::CP_W-1:0]        code_point;
    bsbm_pkg::char_class_t            char_class;
    logic                             boundary_before;
    logic [bsbm_pkg::INDEX_W-1:0]     cp_index;
    bsbm_pkg::err_t                   error;

    // Input register.
    bsbm_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .take          (in_ctrl.take),
        .valid         (in_valid),
        .word          (in_word)
    );

    // Decode, classify and mark boundaries.
    bsbm_core #(
        .MAX_CODEPOINTS (MAX_CODEPOINTS)
    ) u_core (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_word             (in_word),
        .in_valid            (in_valid),
        .in_ctrl             (in_ctrl),
        .out_valid           (m_axis_tvalid),
        .out_ready           (m_axis_tready),
        .out_code_point      (code_point),
        .out_char_class      (char_class),
        .out_boundary_before (boundary_before),
        .out_cp_index        (cp_index),
        .out_end_of_query    (m_axis_tlast),
        .out_error           (error)
    );

    // Pack the result word, lowest field first.
    assign m_axis_tdata = {{bsbm_pkg::OUT_PAD_W{1'b0}}, error, cp_index, boundary_before,
                           char_class, code_point};

endmodule
